/* src/assert_macros.svh */
// assertion macros used by the rtl file quad_corner_order_core.sv
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define QCO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define QCO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/qco_pkg.sv */
// constants and types for the quad corner ordering block
// no dependencies
package qco_pkg;

  localparam int NUM_CORNERS  = 4;
  localparam int NUM_PAIRINGS = 3;
  localparam int CODE_BITS    = 3;
  localparam int USER_BITS    = CODE_BITS + 1;

  typedef logic [1:0] corner_idx_t;

  // candidate diagonal pairings, tried in this order: (a1, a2, b1, b2)
  localparam corner_idx_t PAIRING [NUM_PAIRINGS][NUM_CORNERS] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };

  localparam logic [CODE_BITS-1:0] CODE_PASSTHROUGH = '0;

endpackage

/* src/quad_corner_order_core.sv */
// quad corner ordering core: four-stage stream pipeline, top level
// depends on qco_pkg and assert_macros.svh
//
// usage:
//   s_axis carries one quad per item: eight coordinates of COORD_BITS each,
//   corner a x/y first. m_axis returns the four corners in a consistent
//   winding with tuser = {order_ok, order_code}. when no pair of candidate
//   diagonals crosses, the corners pass through unchanged with ok and code 0.
//   pipeline: input register, difference/centroid stage, cross product stage
//   and result register. an accepted item passes through them in that order
//   and its result is valid once it reaches the result register; one item
//   per cycle is sustained while m_axis_tready_i is high. each stage has its
//   own valid bit and moves whenever the stage after it is empty or moving,
//   so bubbles collapse and new items are taken while a finished result
//   waits. when m_axis_tready_i stays low the four stages fill and then
//   s_axis_tready_o drops. reset empties all stages; nothing else is held
//   between items. the cross products are 2*COORD_BITS+3 bits wide.
`include "assert_macros.svh"

module quad_corner_order_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y,
  // corner_c_x, corner_c_y, corner_d_x, corner_d_y
  input  logic [8*COORD_BITS-1:0]       s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_first_x, out_first_y, out_second_x, out_second_y,
  // out_third_x, out_third_y, out_fourth_x, out_fourth_y
  output logic [8*COORD_BITS-1:0]       m_axis_tdata_o,
  // order_code, order_ok
  output logic [qco_pkg::USER_BITS-1:0] m_axis_tuser_o
);
  import qco_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;       // signed difference
  localparam int MW = 2 * DW;       // signed product
  localparam int PW = MW + 1;       // difference of two products

  typedef logic [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [MW-1:0] prod_t;
  typedef logic signed [PW-1:0] cross_t;

  // num/den lies in the closed unit range, den nonzero
  function automatic logic frac_in_unit(input cross_t num, input cross_t den);
    logic res;
    if (!den[PW-1]) begin
      res = !num[PW-1] && (num <= den);
    end else begin
      res = (num[PW-1] || (num == '0)) && (num >= den);
    end
    return res;
  endfunction

  // ---------------- handshake ----------------
  logic a_v_q, b_v_q, c_v_q, o_v_q;
  logic a_rdy, b_rdy, c_rdy, o_rdy;

  assign o_rdy = !o_v_q || m_axis_tready_i;
  assign c_rdy = !c_v_q || o_rdy;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;

  assign s_axis_tready_o = a_rdy;
  assign m_axis_tvalid_o = o_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= s_axis_tvalid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (o_rdy) o_v_q <= c_v_q;
    end
  end

  // ---------------- stage a: input register ----------------
  coord_t a_x_q [NUM_CORNERS];
  coord_t a_y_q [NUM_CORNERS];

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && a_rdy) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        a_x_q[k] <= s_axis_tdata_i[(2*k)*CW +: CW];
        a_y_q[k] <= s_axis_tdata_i[(2*k+1)*CW +: CW];
      end
    end
  end

  // ---------------- stage b: differences and centred corners ----------------
  coord_t b_x_q [NUM_CORNERS];
  coord_t b_y_q [NUM_CORNERS];
  diff_t  b_adx_q [NUM_PAIRINGS], b_ady_q [NUM_PAIRINGS];
  diff_t  b_bdx_q [NUM_PAIRINGS], b_bdy_q [NUM_PAIRINGS];
  diff_t  b_ox_q  [NUM_PAIRINGS], b_oy_q  [NUM_PAIRINGS];
  diff_t  b_vx_q  [NUM_CORNERS],  b_vy_q  [NUM_CORNERS];

  diff_t  b_adx_d [NUM_PAIRINGS], b_ady_d [NUM_PAIRINGS];
  diff_t  b_bdx_d [NUM_PAIRINGS], b_bdy_d [NUM_PAIRINGS];
  diff_t  b_ox_d  [NUM_PAIRINGS], b_oy_d  [NUM_PAIRINGS];
  diff_t  b_vx_d  [NUM_CORNERS],  b_vy_d  [NUM_CORNERS];

  always_comb begin
    logic [CW+1:0] sum_x, sum_y;
    coord_t        ctr_x, ctr_y;
    corner_idx_t   a1, a2, b1, b2;
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      sum_x = sum_x + {2'b00, a_x_q[k]};
      sum_y = sum_y + {2'b00, a_y_q[k]};
    end
    // floor of the mean: drop two bits
    ctr_x = sum_x[CW+1:2];
    ctr_y = sum_y[CW+1:2];
    for (int k = 0; k < NUM_CORNERS; k++) begin
      b_vx_d[k] = $signed({1'b0, a_x_q[k]}) - $signed({1'b0, ctr_x});
      b_vy_d[k] = $signed({1'b0, a_y_q[k]}) - $signed({1'b0, ctr_y});
    end
    for (int p = 0; p < NUM_PAIRINGS; p++) begin
      a1 = PAIRING[p][0];
      a2 = PAIRING[p][1];
      b1 = PAIRING[p][2];
      b2 = PAIRING[p][3];
      b_adx_d[p] = $signed({1'b0, a_x_q[a2]}) - $signed({1'b0, a_x_q[a1]});
      b_ady_d[p] = $signed({1'b0, a_y_q[a2]}) - $signed({1'b0, a_y_q[a1]});
      b_bdx_d[p] = $signed({1'b0, a_x_q[b2]}) - $signed({1'b0, a_x_q[b1]});
      b_bdy_d[p] = $signed({1'b0, a_y_q[b2]}) - $signed({1'b0, a_y_q[b1]});
      b_ox_d[p]  = $signed({1'b0, a_x_q[a1]}) - $signed({1'b0, a_x_q[b1]});
      b_oy_d[p]  = $signed({1'b0, a_y_q[a1]}) - $signed({1'b0, a_y_q[b1]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_v_q && b_rdy) begin
      b_x_q   <= a_x_q;
      b_y_q   <= a_y_q;
      b_vx_q  <= b_vx_d;
      b_vy_q  <= b_vy_d;
      b_adx_q <= b_adx_d;
      b_ady_q <= b_ady_d;
      b_bdx_q <= b_bdx_d;
      b_bdy_q <= b_bdy_d;
      b_ox_q  <= b_ox_d;
      b_oy_q  <= b_oy_d;
    end
  end

  // ---------------- stage c: cross products ----------------
  coord_t c_x_q [NUM_CORNERS];
  coord_t c_y_q [NUM_CORNERS];
  cross_t c_den_q [NUM_PAIRINGS], c_tn_q [NUM_PAIRINGS];
  cross_t c_sn_q  [NUM_PAIRINGS], c_z_q  [NUM_PAIRINGS];

  cross_t c_den_d [NUM_PAIRINGS], c_tn_d [NUM_PAIRINGS];
  cross_t c_sn_d  [NUM_PAIRINGS], c_z_d  [NUM_PAIRINGS];

  always_comb begin
    prod_t       m0, m1, m2, m3, m4, m5, m6, m7;
    corner_idx_t i2;
    for (int p = 0; p < NUM_PAIRINGS; p++) begin
      i2 = PAIRING[p][2];
      m0 = b_bdy_q[p] * b_adx_q[p];
      m1 = b_bdx_q[p] * b_ady_q[p];
      m2 = b_bdx_q[p] * b_oy_q[p];
      m3 = b_bdy_q[p] * b_ox_q[p];
      m4 = b_adx_q[p] * b_oy_q[p];
      m5 = b_ady_q[p] * b_ox_q[p];
      // winding test: first corner against the corner that opens the other diagonal
      m6 = b_vx_q[0] * b_vy_q[i2];
      m7 = b_vy_q[0] * b_vx_q[i2];
      c_den_d[p] = $signed({m0[MW-1], m0}) - $signed({m1[MW-1], m1});
      c_tn_d[p]  = $signed({m2[MW-1], m2}) - $signed({m3[MW-1], m3});
      c_sn_d[p]  = $signed({m4[MW-1], m4}) - $signed({m5[MW-1], m5});
      c_z_d[p]   = $signed({m6[MW-1], m6}) - $signed({m7[MW-1], m7});
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_v_q && c_rdy) begin
      c_x_q   <= b_x_q;
      c_y_q   <= b_y_q;
      c_den_q <= c_den_d;
      c_tn_q  <= c_tn_d;
      c_sn_q  <= c_sn_d;
      c_z_q   <= c_z_d;
    end
  end

  // ---------------- stage o: select pairing and winding ----------------
  logic [8*CW-1:0]      o_data_q, o_data_d;
  logic [USER_BITS-1:0] o_user_q, o_user_d;

  always_comb begin
    logic [NUM_PAIRINGS-1:0] crosses;
    logic                    found;
    logic [1:0]              sel;
    logic                    flip;
    corner_idx_t             ord [NUM_CORNERS];
    crosses = '0;
    for (int p = 0; p < NUM_PAIRINGS; p++) begin
      crosses[p] = (c_den_q[p] != '0)
                && frac_in_unit(c_tn_q[p], c_den_q[p])
                && frac_in_unit(c_sn_q[p], c_den_q[p])
                && !((c_tn_q[p] == '0) && (c_sn_q[p] == '0));
    end
    found = |crosses;
    sel   = '0;
    // first crossing pairing wins
    for (int p = NUM_PAIRINGS - 1; p >= 0; p--) begin
      if (crosses[p]) sel = 2'(p);
    end
    // flipped winding unless the cross product is strictly positive
    flip = c_z_q[sel][PW-1] || (c_z_q[sel] == '0);
    if (!found) begin
      for (int k = 0; k < NUM_CORNERS; k++) ord[k] = 2'(k);
    end else if (!flip) begin
      ord[0] = PAIRING[sel][0];
      ord[1] = PAIRING[sel][2];
      ord[2] = PAIRING[sel][1];
      ord[3] = PAIRING[sel][3];
    end else begin
      ord[0] = PAIRING[sel][2];
      ord[1] = PAIRING[sel][0];
      ord[2] = PAIRING[sel][3];
      ord[3] = PAIRING[sel][1];
    end
    for (int k = 0; k < NUM_CORNERS; k++) begin
      o_data_d[(2*k)*CW +: CW]   = c_x_q[ord[k]];
      o_data_d[(2*k+1)*CW +: CW] = c_y_q[ord[k]];
    end
    o_user_d = found ? {1'b1, sel, flip} : {1'b0, CODE_PASSTHROUGH};
  end

  always_ff @(posedge clk_i) begin
    if (c_v_q && o_rdy) begin
      o_data_q <= o_data_d;
      o_user_q <= o_user_d;
    end
  end

  assign m_axis_tdata_o = o_data_q;
  assign m_axis_tuser_o = o_user_q;

  // ---------------- assertions ----------------
  `QCO_ASSERT(a_moves_to_b, a_v_q && b_rdy |=> b_v_q, "item lost between stage a and b")
  `QCO_ASSERT(c_moves_to_o, c_v_q && o_rdy |=> o_v_q, "item lost between stage c and output")
  `QCO_ASSERT(pass_code_zero,
    o_v_q && !o_user_q[USER_BITS-1] |-> o_user_q[CODE_BITS-1:0] == CODE_PASSTHROUGH,
    "passthrough result carries a nonzero order code")
  `QCO_ASSERT(code_range,
    o_v_q |-> (o_user_q[CODE_BITS-1:1] != 2'd3),
    "order code names a pairing that does not exist")

endmodule
